@@ design/inverter_trip_detector_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the inverter trip detector
// Clocked, reset-qualified concurrent assertion shorthands.
// ---------------------------------------------------------------------------
`ifndef INVERTER_TRIP_DETECTOR_MACROS_SVH
`define INVERTER_TRIP_DETECTOR_MACROS_SVH

// Check that an expression holds at every clock edge out of reset
`define ITD_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Check that a consequent holds whenever the antecedent holds
`define ITD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a consequent holds in the cycle after the antecedent
`define ITD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/itd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Inverter trip detector package
// Shared register layout, trip codes, filter bounds and helper functions.
// ---------------------------------------------------------------------------
package itd_pkg;

	// Field widths
	localparam int unsigned CUR_W   = 13;
	localparam int unsigned VBUS_W  = 14;
	localparam int unsigned TEMP_W  = 12;
	localparam int unsigned EN_W    = 4;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned CFG_DW  = 14;

	// Input and output stream widths (packed fields, padded to bytes)
	localparam int unsigned IN_BITS  = 2 * CUR_W + VBUS_W + TEMP_W + 1;
	localparam int unsigned IN_TDW   = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDW  = ((CODE_W + 7) / 8) * 8;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_CHECK_ENABLES = 3'd0;
	localparam logic [ADDR_W-1:0] REG_CUR_HIGH      = 3'd1;
	localparam logic [ADDR_W-1:0] REG_CUR_LOW       = 3'd2;
	localparam logic [ADDR_W-1:0] REG_OV_LEVEL      = 3'd3;
	localparam logic [ADDR_W-1:0] REG_UV_LEVEL      = 3'd4;
	localparam logic [ADDR_W-1:0] REG_OH_LEVEL      = 3'd5;

	// Enable bit positions
	localparam int unsigned EN_CURRENT  = 0;
	localparam int unsigned EN_OVERVOLT = 1;
	localparam int unsigned EN_UNDERVOLT = 2;
	localparam int unsigned EN_OVERHEAT = 3;

	// Reset values of the registers (bus levels in Q10.4 volts)
	localparam logic [EN_W-1:0]   RST_CHECK_ENABLES = 4'd15;
	localparam logic [CUR_W-1:0]  RST_CUR_HIGH      = 13'd3000;
	localparam logic [CUR_W-1:0]  RST_CUR_LOW       = 13'd1000;
	localparam logic [VBUS_W-1:0] RST_OV_LEVEL      = 14'd5600;
	localparam logic [VBUS_W-1:0] RST_UV_LEVEL      = 14'd2880;
	localparam logic [TEMP_W-1:0] RST_OH_LEVEL      = 12'd1000;

	// Trip codes
	localparam logic [CODE_W-1:0] TRIP_NONE      = 3'd0;
	localparam logic [CODE_W-1:0] TRIP_U_CURRENT = 3'd1;
	localparam logic [CODE_W-1:0] TRIP_V_CURRENT = 3'd2;
	localparam logic [CODE_W-1:0] TRIP_OVERVOLT  = 3'd3;
	localparam logic [CODE_W-1:0] TRIP_UNDERVOLT = 3'd4;
	localparam logic [CODE_W-1:0] TRIP_OVERHEAT  = 3'd5;
	localparam logic [CODE_W-1:0] TRIP_IGBT      = 3'd6;

	// Filter counters: width, trip bound, saturation value
	localparam int unsigned OV_CNT_W      = 3;
	localparam int unsigned UV_CNT_W      = 3;
	localparam int unsigned OH_CNT_W      = 4;
	localparam int unsigned OV_TRIP_BOUND = 5;
	localparam int unsigned UV_TRIP_BOUND = 5;
	localparam int unsigned OH_TRIP_BOUND = 10;
	localparam logic [OV_CNT_W-1:0] OV_SAT = OV_CNT_W'(OV_TRIP_BOUND + 1);
	localparam logic [UV_CNT_W-1:0] UV_SAT = UV_CNT_W'(UV_TRIP_BOUND + 1);
	localparam logic [OH_CNT_W-1:0] OH_SAT = OH_CNT_W'(OH_TRIP_BOUND + 1);

	// Configuration register file contents
	typedef struct packed {
		logic [EN_W-1:0]   check_enables;
		logic [CUR_W-1:0]  current_high_limit;
		logic [CUR_W-1:0]  current_low_limit;
		logic [VBUS_W-1:0] overvolt_level;
		logic [VBUS_W-1:0] undervolt_level;
		logic [TEMP_W-1:0] overheat_level;
	} cfg_t;

	// Magnitude of a signed 13-bit sample; the most negative code gives 4096
	function automatic logic [CUR_W-1:0] magnitude(input logic signed [CUR_W-1:0] v);
		logic [CUR_W-1:0] raw;
		raw = v;
		return raw[CUR_W-1] ? (~raw + CUR_W'(1)) : raw;
	endfunction

	// Window check on a current magnitude
	function automatic logic window_trip(input logic [CUR_W-1:0] mag,
			input logic [CUR_W-1:0] hi, input logic [CUR_W-1:0] lo);
		return (mag > hi) || (mag < lo);
	endfunction

endpackage
`default_nettype wire

@@ design/inverter_trip_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Inverter trip detector
// Per-tick inverter protection: current window, filtered bus voltage and
// heat checks, gate driver fault, reported as one prioritized trip code.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one protection tick per transaction: both phase currents,
//   the bus voltage, the IGBT temperature reading and the gate fault line.
//   m_axis returns exactly one trip code per tick, in tick order.
//   Configuration is written through cfg_wr_en / cfg_addr / cfg_data while
//   no tick is in flight; writes take effect on the next clock edge.
// Path: a tick passes the input register, then the check logic and counter
//   update, into the result register that drives m_axis_tvalid.
// Throughput: one tick per cycle while m_axis_tready is high, set by the
//   single evaluate stage between the input and result registers; the filter
//   counters of the checks a tick reaches step as it enters the result register.
// Reset: arst_n clears the valid flags of both pipeline stages and the filter
//   counters and loads the default enables, current window and levels.
// Stall: with m_axis_tready low the result is held, one more tick may sit in
//   the input register, and s_axis_tready drops once both are occupied.
// ---------------------------------------------------------------------------
`include "inverter_trip_detector_macros.svh"

module inverter_trip_detector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Input ticks
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// [12:0] current_u, [25:13] current_v, [39:26] bus_voltage,
	// [51:40] igbt_temp, [52] gate_fault_n, [55:53] zero
	input  wire logic [itd_pkg::IN_TDW-1:0]  s_axis_tdata,
	// Trip codes
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [2:0] fault_code, [7:3] zero
	output logic [itd_pkg::OUT_TDW-1:0]      m_axis_tdata,
	// Configuration writes
	input  wire logic                        cfg_wr_en,
	input  wire logic [itd_pkg::ADDR_W-1:0]  cfg_addr,
	input  wire logic [itd_pkg::CFG_DW-1:0]  cfg_data
);
	import itd_pkg::*;

	cfg_t cfg;

	// Stage 1: captured tick
	logic                     valid_s1;
	logic signed [CUR_W-1:0]  current_u_s1;
	logic signed [CUR_W-1:0]  current_v_s1;
	logic [VBUS_W-1:0]        bus_voltage_s1;
	logic [TEMP_W-1:0]        igbt_temp_s1;
	logic                     gate_fault_n_s1;

	// Stage 2: result
	logic                     valid_s2;
	logic [CODE_W-1:0]        fault_code_s2;

	logic                     in_fire;
	logic                     advance;
	logic                     en_cur, en_ov, en_uv, en_oh;
	logic                     trip_u, trip_v, trip_ov, trip_uv, trip_oh;
	logic                     reach_ov, reach_uv, reach_oh;
	logic                     flt_ov, flt_uv, flt_oh;
	logic                     cond_ov, cond_uv, cond_oh;
	logic [OV_CNT_W-1:0]      ov_count;
	logic [UV_CNT_W-1:0]      uv_count;
	logic [OH_CNT_W-1:0]      oh_count;
	logic [CODE_W-1:0]        fault_code_next;

	itd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.addr   (cfg_addr),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Handshake: advance when the result slot is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Capture the incoming tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			current_u_s1    <= s_axis_tdata[CUR_W-1:0];
			current_v_s1    <= s_axis_tdata[2*CUR_W-1:CUR_W];
			bus_voltage_s1  <= s_axis_tdata[2*CUR_W+VBUS_W-1:2*CUR_W];
			igbt_temp_s1    <= s_axis_tdata[2*CUR_W+VBUS_W+TEMP_W-1:2*CUR_W+VBUS_W];
			gate_fault_n_s1 <= s_axis_tdata[2*CUR_W+VBUS_W+TEMP_W];
		end
	end

	// Evaluate the checks in priority order
	assign en_cur  = cfg.check_enables[EN_CURRENT];
	assign en_ov   = cfg.check_enables[EN_OVERVOLT];
	assign en_uv   = cfg.check_enables[EN_UNDERVOLT];
	assign en_oh   = cfg.check_enables[EN_OVERHEAT];

	assign cond_ov = bus_voltage_s1 > cfg.overvolt_level;
	assign cond_uv = bus_voltage_s1 < cfg.undervolt_level;
	assign cond_oh = igbt_temp_s1 < cfg.overheat_level;

	assign trip_u  = en_cur && window_trip(magnitude(current_u_s1),
		cfg.current_high_limit, cfg.current_low_limit);
	assign trip_v  = en_cur && !trip_u && window_trip(magnitude(current_v_s1),
		cfg.current_high_limit, cfg.current_low_limit);

	// A check after a tripping one is skipped and keeps its counter
	assign reach_ov = en_ov && !trip_u && !trip_v;
	assign trip_ov  = reach_ov && flt_ov;
	assign reach_uv = en_uv && !trip_u && !trip_v && !trip_ov;
	assign trip_uv  = reach_uv && flt_uv;
	assign reach_oh = en_oh && !trip_u && !trip_v && !trip_ov && !trip_uv;
	assign trip_oh  = reach_oh && flt_oh;

	itd_filter #(.WIDTH(OV_CNT_W), .BOUND(OV_TRIP_BOUND)) u_ov_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && reach_ov),
		.cond   (cond_ov),
		.trip   (flt_ov),
		.count  (ov_count)
	);

	itd_filter #(.WIDTH(UV_CNT_W), .BOUND(UV_TRIP_BOUND)) u_uv_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && reach_uv),
		.cond   (cond_uv),
		.trip   (flt_uv),
		.count  (uv_count)
	);

	itd_filter #(.WIDTH(OH_CNT_W), .BOUND(OH_TRIP_BOUND)) u_oh_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && reach_oh),
		.cond   (cond_oh),
		.trip   (flt_oh),
		.count  (oh_count)
	);

	// Select the first tripping check
	always_comb begin
		if (trip_u) begin
			fault_code_next = TRIP_U_CURRENT;
		end else if (trip_v) begin
			fault_code_next = TRIP_V_CURRENT;
		end else if (trip_ov) begin
			fault_code_next = TRIP_OVERVOLT;
		end else if (trip_uv) begin
			fault_code_next = TRIP_UNDERVOLT;
		end else if (trip_oh) begin
			fault_code_next = TRIP_OVERHEAT;
		end else if (!gate_fault_n_s1) begin
			fault_code_next = TRIP_IGBT;
		end else begin
			fault_code_next = TRIP_NONE;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fault_code_s2 <= fault_code_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDW - CODE_W){1'b0}}, fault_code_s2};

	// Assertions
	`ITD_ASSERT_ALWAYS(a_count_sat, clk, arst_n, (ov_count <= OV_SAT) && (uv_count <= UV_SAT) && (oh_count <= OH_SAT), "filter counter above saturation value")
	`ITD_ASSERT_NEXT(a_ov_trip_sat, clk, arst_n, advance && (fault_code_next == TRIP_OVERVOLT), ov_count == OV_SAT, "overvoltage trip without saturated counter")
	`ITD_ASSERT_IMPLY(a_stall_full, clk, arst_n, !s_axis_tready, valid_s1 && valid_s2 && !m_axis_tready, "input stalled while a stage is free")
	`ITD_ASSERT_IMPLY(a_code_range, clk, arst_n, valid_s2, fault_code_s2 <= TRIP_IGBT, "trip code out of range")

endmodule
`default_nettype wire

@@ design/itd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Trip detector configuration registers
// Write-only register file for the check enables, current window and levels.
// ---------------------------------------------------------------------------
module itd_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [itd_pkg::ADDR_W-1:0] addr,
	input  wire logic [itd_pkg::CFG_DW-1:0] data,
	output itd_pkg::cfg_t                  cfg
);
	import itd_pkg::*;

	cfg_t cfg_q;

	// Decode the index and latch the addressed register; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_enables      <= RST_CHECK_ENABLES;
			cfg_q.current_high_limit <= RST_CUR_HIGH;
			cfg_q.current_low_limit  <= RST_CUR_LOW;
			cfg_q.overvolt_level     <= RST_OV_LEVEL;
			cfg_q.undervolt_level    <= RST_UV_LEVEL;
			cfg_q.overheat_level     <= RST_OH_LEVEL;
		end else if (wr_en) begin
			unique case (addr)
				REG_CHECK_ENABLES: cfg_q.check_enables      <= data[EN_W-1:0];
				REG_CUR_HIGH:      cfg_q.current_high_limit <= data[CUR_W-1:0];
				REG_CUR_LOW:       cfg_q.current_low_limit  <= data[CUR_W-1:0];
				REG_OV_LEVEL:      cfg_q.overvolt_level     <= data[VBUS_W-1:0];
				REG_UV_LEVEL:      cfg_q.undervolt_level    <= data[VBUS_W-1:0];
				REG_OH_LEVEL:      cfg_q.overheat_level     <= data[TEMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ design/itd_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Trip detector up/down filter
// Saturating up/down counter that trips once it climbs past its bound.
// ---------------------------------------------------------------------------
module itd_filter #(
	parameter int unsigned WIDTH = itd_pkg::OV_CNT_W,
	parameter int unsigned BOUND = itd_pkg::OV_TRIP_BOUND
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,   // advance the counter this cycle
	input  wire logic             cond,   // fault condition seen this tick
	output logic                  trip,   // trip if stepped with this cond
	output logic [WIDTH-1:0]      count
);
	import itd_pkg::*;

	logic [WIDTH-1:0] count_q;
	logic [WIDTH-1:0] sum;
	logic [WIDTH-1:0] count_next;

	// Count up on the condition, otherwise decay toward zero
	always_comb begin
		if (cond) begin
			sum = count_q + WIDTH'(1);
		end else if (count_q != '0) begin
			sum = count_q - WIDTH'(1);
		end else begin
			sum = '0;
		end
		trip       = sum > WIDTH'(BOUND);
		count_next = trip ? WIDTH'(BOUND + 1) : sum;
	end

	// Hold the count unless this check is reached in an evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= count_next;
		end
	end

	assign count = count_q;

endmodule
`default_nettype wire
